@@ hdl/sitd_pkg.sv @@
// Shared types and constants for the signed integer to radix digits block.
// Holds the character codes, register map, and controller/datapath structs.
// No dependencies.
package sitd_pkg;

   localparam int DEF_MAX_BASE     = 16;
   localparam int DEF_NUMBER_WIDTH = 32;

   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 5;
   localparam int RADIX_W     = 5;
   localparam int ALPHA_BYTES = 16;
   localparam int ALPHA_W     = 8 * ALPHA_BYTES;
   localparam int CHAR_W      = 8;
   localparam int ALPHA_IDX_W = 4;

   // Dividend bits consumed per cycle by the remainder unit.
   localparam int STEP_BITS = 8;

   localparam logic [CHAR_W-1:0]  MINUS_CHAR = 8'h2D;
   localparam logic [CHAR_W-1:0]  PLUS_CHAR  = 8'h2B;
   localparam logic [RADIX_W-1:0] MIN_BASE   = 5'd2;

   typedef enum logic [1:0] {
      REG_ALPHA_LOW,
      REG_ALPHA_HIGH,
      REG_BASE_LEN
   } csr_reg_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic div_last;
      logic emit_sign;
      logic emit_digit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic neg;
      logic quot_zero;
      logic count_full;
      logic count_last;
   } dp_status_type;

endpackage

@@ hdl/sitd_csr.sv @@
// Configuration registers with the APB-style access port, plus the alphabet check.
// The check result is registered each cycle for the controller.
// Depends on sitd_pkg.
module sitd_csr import sitd_pkg::*; #(
   parameter int MAX_BASE = DEF_MAX_BASE
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [ALPHA_W-1:0]    alphabet,
   output logic [RADIX_W-1:0]    radix,
   output logic                  alpha_ok
);

   logic [CSR_DATA_W-1:0] alpha_low_ff;
   logic [CSR_DATA_W-1:0] alpha_high_ff;
   logic [RADIX_W-1:0]    base_len_ff;
   logic                  alpha_ok_ff;
   logic                  alpha_ok_in;
   csr_reg_type           reg_sel;
   logic                  wr_en;

   assign reg_sel = csr_reg_type'(paddr[4:3]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_low_ff  <= '0;
         alpha_high_ff <= '0;
         base_len_ff   <= '0;
         alpha_ok_ff   <= 1'b0;
      end else begin
         alpha_ok_ff <= alpha_ok_in;
         if (wr_en) begin
            unique case (reg_sel)
               REG_ALPHA_LOW:  alpha_low_ff  <= pwdata;
               REG_ALPHA_HIGH: alpha_high_ff <= pwdata;
               REG_BASE_LEN:   base_len_ff   <= pwdata[RADIX_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_ALPHA_LOW:  prdata = alpha_low_ff;
         REG_ALPHA_HIGH: prdata = alpha_high_ff;
         REG_BASE_LEN:   prdata = {{(CSR_DATA_W-RADIX_W){1'b0}}, base_len_ff};
         default:        prdata = '0;
      endcase
   end

   assign alphabet = {alpha_high_ff, alpha_low_ff};
   assign radix    = base_len_ff;
   assign alpha_ok = alpha_ok_ff;

   // Checks the length, signs, and every pair of used characters, in parallel.
   always_comb begin
      logic ok;
      logic [CHAR_W-1:0] ch;
      ok = (base_len_ff >= MIN_BASE) && (base_len_ff <= RADIX_W'(MAX_BASE));
      for (int i = 0; i < ALPHA_BYTES; i++) begin
         ch = alphabet[8*i +: 8];
         if (RADIX_W'(i) < base_len_ff) begin
            if (ch == PLUS_CHAR || ch == MINUS_CHAR) ok = 1'b0;
            for (int j = i + 1; j < ALPHA_BYTES; j++) begin
               if (RADIX_W'(j) < base_len_ff && alphabet[8*j +: 8] == ch) ok = 1'b0;
            end
         end
      end
      alpha_ok_in = ok;
   end

endmodule

@@ hdl/sitd_dpath.sv @@
// Datapath: magnitude register, remainder unit, digit stack and output register.
// Driven by command structs from sitd_ctrl; depends on sitd_pkg.
module sitd_dpath import sitd_pkg::*; #(
   parameter int MAX_BASE     = DEF_MAX_BASE,
   parameter int NUMBER_WIDTH = DEF_NUMBER_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ctrl_cmd_type            cmd,
   output dp_status_type           status,
   input  logic [NUMBER_WIDTH-1:0] number,
   input  logic [ALPHA_W-1:0]      alphabet,
   input  logic [RADIX_W-1:0]      radix,
   output logic                    rsp_strobe,
   output logic [CHAR_W-1:0]       rsp_character,
   output logic                    rsp_last_char
);

   localparam int DIV_CYC = (NUMBER_WIDTH + STEP_BITS - 1) / STEP_BITS;
   localparam int PAD_W   = DIV_CYC * STEP_BITS;
   localparam int REM_W   = $clog2(MAX_BASE);
   localparam int IDX_W   = $clog2(NUMBER_WIDTH);
   localparam int CNT_W   = $clog2(NUMBER_WIDTH + 1);

   logic [PAD_W-1:0]     sh_ff;
   logic [PAD_W-1:0]     sh_in;
   logic [REM_W-1:0]     rem_ff;
   logic [REM_W-1:0]     rem_in;
   logic [STEP_BITS-1:0] qbits;
   logic                 neg_ff;
   logic [CNT_W-1:0]     nd_ff;
   logic [REM_W-1:0]     digit_mem [NUMBER_WIDTH];
   logic [REM_W:0]       radix_w;
   logic [NUMBER_WIDTH-1:0] mag;
   logic [IDX_W-1:0]     rd_idx;
   logic [REM_W-1:0]     rd_digit;
   logic [CNT_W-1:0]     nd_dec;

   logic                 rsp_strobe_ff;
   logic [CHAR_W-1:0]    rsp_character_ff;
   logic                 rsp_last_char_ff;

   // Negation wraps the most negative value onto its exact magnitude.
   assign mag     = number[NUMBER_WIDTH-1] ? (~number + 1'b1) : number;
   assign radix_w = radix[REM_W:0];

   // Restoring division by the radix, STEP_BITS quotient bits per cycle.
   always_comb begin
      logic [REM_W-1:0] r;
      logic [REM_W:0]   t;
      r = rem_ff;
      for (int k = 0; k < STEP_BITS; k++) begin
         t = {r, sh_ff[PAD_W-1-k]};
         if (t >= radix_w) begin
            r = REM_W'(t - radix_w);
            qbits[STEP_BITS-1-k] = 1'b1;
         end else begin
            r = t[REM_W-1:0];
            qbits[STEP_BITS-1-k] = 1'b0;
         end
      end
      rem_in = r;
   end

   always_comb begin
      logic [PAD_W+STEP_BITS-1:0] wide;
      wide  = {sh_ff, qbits};
      sh_in = wide[PAD_W-1:0];
   end

   assign nd_dec   = nd_ff - 1'b1;
   assign rd_idx   = nd_dec[IDX_W-1:0];
   assign rd_digit = digit_mem[rd_idx];

   assign status.neg        = neg_ff;
   assign status.quot_zero  = (sh_in == '0);
   assign status.count_full = (nd_ff == CNT_W'(NUMBER_WIDTH - 1));
   assign status.count_last = (nd_ff == CNT_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         nd_ff         <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.emit_sign || cmd.emit_digit;
         if (cmd.load) begin
            nd_ff <= '0;
         end else if (cmd.div_step && cmd.div_last) begin
            nd_ff <= nd_ff + 1'b1;
         end else if (cmd.emit_digit) begin
            nd_ff <= nd_dec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sh_ff  <= PAD_W'(mag);
         neg_ff <= number[NUMBER_WIDTH-1];
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         sh_ff  <= sh_in;
         rem_ff <= cmd.div_last ? '0 : rem_in;
      end
      if (cmd.div_step && cmd.div_last) begin
         digit_mem[nd_ff[IDX_W-1:0]] <= rem_in;
      end
      if (cmd.emit_sign) begin
         rsp_character_ff <= MINUS_CHAR;
         rsp_last_char_ff <= 1'b0;
      end else if (cmd.emit_digit) begin
         rsp_character_ff <= alphabet[8*int'(ALPHA_IDX_W'(rd_digit)) +: 8];
         rsp_last_char_ff <= status.count_last;
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last_char = rsp_last_char_ff;

   a_last_then_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_last_char_ff |=> !rsp_strobe_ff)
      else $error("character strobed right after the final character");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_digit |-> nd_ff != '0)
      else $error("digit emitted from an empty digit stack");

   a_radix_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> radix >= MIN_BASE)
      else $error("division started with a radix below two");

endmodule

@@ hdl/sitd_ctrl.sv @@
// Controller state machine: sequences check, division, sign and digit output.
// Issues commands to sitd_dpath; depends on sitd_pkg.
module sitd_ctrl import sitd_pkg::*; #(
   parameter int NUMBER_WIDTH = DEF_NUMBER_WIDTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  logic          alpha_ok,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   localparam int DIV_CYC = (NUMBER_WIDTH + STEP_BITS - 1) / STEP_BITS;
   localparam int STEP_W  = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_SIGN,
      ST_EMIT
   } state_type;

   state_type        state_ff;
   logic [STEP_W-1:0] step_ff;
   logic             step_last;
   logic             div_done;

   assign step_last = (step_ff == STEP_W'(DIV_CYC - 1));
   assign div_done  = step_last && (status.quot_zero || status.count_full);
   assign busy      = (state_ff != ST_IDLE);

   always_comb begin
      cmd            = '0;
      cmd.load       = (state_ff == ST_IDLE) && start;
      cmd.div_step   = (state_ff == ST_DIVIDE);
      cmd.div_last   = (state_ff == ST_DIVIDE) && step_last;
      cmd.emit_sign  = (state_ff == ST_SIGN);
      cmd.emit_digit = (state_ff == ST_EMIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (start) state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               step_ff  <= '0;
               state_ff <= alpha_ok ? ST_DIVIDE : ST_IDLE;
            end
            ST_DIVIDE: begin
               step_ff <= step_last ? '0 : step_ff + 1'b1;
               if (div_done) state_ff <= status.neg ? ST_SIGN : ST_EMIT;
            end
            ST_SIGN: begin
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (status.count_last) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_bad_alphabet_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CHECK && !alpha_ok |=> state_ff == ST_IDLE)
      else $error("conversion continued with an invalid alphabet");

   a_final_digit_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_digit && status.count_last |=> state_ff == ST_IDLE)
      else $error("controller stayed busy after the final digit");

   a_sign_only_neg: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_sign |-> status.neg)
      else $error("minus sign emitted for a non-negative number");

endmodule

@@ hdl/signed_integer_to_radix_digits_top.sv @@
// Top level of the signed integer to radix digits converter.
// Usage:
//   Configure alphabet_low (0x00), alphabet_high (0x08) and base_length (0x10)
//   through the APB-style port while the block is idle; pready is always high.
//   Present a number on req_number with start high; it is taken at the edge
//   where start is high and busy is low.
//   The text comes out one character per transaction on rsp_character, each
//   valid for one cycle while rsp_strobe is high; rsp_last_char marks the end.
//   A negative number gives a leading minus sign. An invalid alphabet gives
//   no characters and the block returns to idle straight from the check state.
// Sequence after acceptance:
//   busy stays high through the check state, the divide state, where the
//   8-bit-per-cycle remainder unit builds each digit, and the sign and emit
//   states, which give one character per cycle. A new number can be taken in
//   the cycle the final character is shown. The receiver cannot stall the output.
// Reset is synchronous; it clears the configuration registers, the controller
// state, the digit count and the output strobe, and returns the block to idle.
// Depends on sitd_pkg, sitd_csr, sitd_dpath and sitd_ctrl.
module signed_integer_to_radix_digits_top import sitd_pkg::*; #(
   parameter int MAX_BASE     = DEF_MAX_BASE,
   parameter int NUMBER_WIDTH = DEF_NUMBER_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [NUMBER_WIDTH-1:0] req_number,
   output logic                    rsp_strobe,
   output logic [CHAR_W-1:0]       rsp_character,
   output logic                    rsp_last_char,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CSR_ADDR_W-1:0]   paddr,
   input  logic [CSR_DATA_W-1:0]   pwdata,
   output logic [CSR_DATA_W-1:0]   prdata,
   output logic                    pready
);

   logic [ALPHA_W-1:0] alphabet;
   logic [RADIX_W-1:0] radix;
   logic               alpha_ok;
   ctrl_cmd_type       cmd;
   dp_status_type      status;

   sitd_csr #(
      .MAX_BASE (MAX_BASE)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .alphabet (alphabet),
      .radix    (radix),
      .alpha_ok (alpha_ok)
   );

   sitd_ctrl #(
      .NUMBER_WIDTH (NUMBER_WIDTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .alpha_ok (alpha_ok),
      .status   (status),
      .cmd      (cmd)
   );

   sitd_dpath #(
      .MAX_BASE     (MAX_BASE),
      .NUMBER_WIDTH (NUMBER_WIDTH)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .number        (req_number),
      .alphabet      (alphabet),
      .radix         (radix),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_last_char (rsp_last_char)
   );

endmodule

@@ test/signed_integer_to_radix_digits_top_tb.sv @@
// Self-checking testbench for signed_integer_to_radix_digits_top: a queue-fed driver,
// a strobe monitor and an in-bench predictor of the character stream for each number.
// Depends on sitd_pkg and the top level of the converter.
`timescale 1ns / 100ps

module signed_integer_to_radix_digits_top_tb;
   import sitd_pkg::*;

   localparam int NUM_W          = DEF_NUMBER_WIDTH;
   localparam int RADIX_MAX      = DEF_MAX_BASE;
   localparam int CSR_STRIDE     = 8;
   localparam int REG_UNMAPPED   = 3;
   localparam int MAX_GAP        = 18;
   localparam int RANDOM_NUMBERS = 410;
   localparam int DRAIN_CYCLES   = 170;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last_char;
   } text_char_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [NUM_W-1:0]      req_number = '0;
   logic                  rsp_strobe;
   logic [CHAR_W-1:0]     rsp_character;
   logic                  rsp_last_char;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Shadow copies of the configuration registers.
   logic [63:0]        alpha_low_m = '0;
   logic [63:0]        alpha_high_m = '0;
   logic [RADIX_W-1:0] radix_m = '0;

   logic [NUM_W-1:0] pending_numbers[$];
   text_char_type    expected_text[$];

   int  numbers_sent = 0;
   int  numbers_accepted = 0;
   int  chars_predicted = 0;
   int  chars_checked = 0;
   int  error_count = 0;
   int  hold_off = 0;
   int  quiet_cycles = 0;
   bit  no_idle = 1'b0;

   signed_integer_to_radix_digits_top #(
      .MAX_BASE    (RADIX_MAX),
      .NUMBER_WIDTH(NUM_W)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_number   (req_number),
      .rsp_strobe   (rsp_strobe),
      .rsp_character(rsp_character),
      .rsp_last_char(rsp_last_char),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready)
   );

   always #1 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      error_count++;
   endtask

   function automatic logic [CHAR_W-1:0] alpha_char(input int digit);
      logic [127:0] alpha;
      alpha = {alpha_high_m, alpha_low_m};
      return alpha[8*digit +: 8];
   endfunction

   function automatic bit alphabet_ok();
      int n;
      n = int'(radix_m);
      if (n < int'(MIN_BASE) || n > RADIX_MAX) return 1'b0;
      for (int i = 0; i < n; i++) begin
         if (alpha_char(i) == PLUS_CHAR || alpha_char(i) == MINUS_CHAR) return 1'b0;
         for (int j = i + 1; j < n; j++) begin
            if (alpha_char(j) == alpha_char(i)) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // Appends the expected text of one number and returns its length.
   function automatic int predict_text(input logic [NUM_W-1:0] value);
      logic [CHAR_W-1:0] digits[$];
      logic [NUM_W-1:0]  mag;
      logic [NUM_W-1:0]  radix;
      text_char_type     tc;
      int                count;
      count = 0;
      if (!alphabet_ok()) return 0;
      radix = NUM_W'(radix_m);
      // Unsigned negation gives the exact magnitude of the most negative value too.
      mag = value[NUM_W-1] ? (~value + 1'b1) : value;
      do begin
         digits.push_back(alpha_char(int'(mag % radix)));
         mag = mag / radix;
      end while (mag != 0 && digits.size() < NUM_W);
      if (value[NUM_W-1]) begin
         tc.character = MINUS_CHAR;
         tc.last_char = 1'b0;
         expected_text.push_back(tc);
         count++;
      end
      for (int k = digits.size() - 1; k >= 0; k--) begin
         tc.character = digits[k];
         tc.last_char = (k == 0);
         expected_text.push_back(tc);
         count++;
      end
      return count;
   endfunction

   // Driver: presents queued numbers on the command port with random gaps, or back to back when no_idle is set.
   always @(posedge clock) begin : drive_numbers
      int gap;
      int n;
      if (reset) begin
         start <= 1'b0;
         hold_off <= 0;
      end else if (start && !busy) begin
         n = predict_text(req_number);
         numbers_accepted <= numbers_accepted + 1;
         chars_predicted <= chars_predicted + n;
         gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
         if (gap == 0 && pending_numbers.size() != 0) begin
            req_number <= pending_numbers.pop_front();
         end else begin
            start <= 1'b0;
            hold_off <= gap;
            req_number <= $urandom();
         end
      end else if (!start) begin
         if (hold_off != 0) begin
            hold_off <= hold_off - 1;
            req_number <= $urandom();
         end else if (pending_numbers.size() != 0) begin
            start <= 1'b1;
            req_number <= pending_numbers.pop_front();
         end else begin
            req_number <= $urandom();
         end
      end
   end

   // Monitor: every strobed character is checked against the oldest expectation.
   always @(posedge clock) begin : check_text
      text_char_type want;
      if (!reset && rsp_strobe) begin
         if (expected_text.size() == 0) begin
            report_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                      rsp_character, rsp_last_char));
         end else begin
            want = expected_text.pop_front();
            chars_checked <= chars_checked + 1;
            if (rsp_character !== want.character) begin
               report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                         rsp_character, want.character));
            end
            if (rsp_last_char !== want.last_char) begin
               report_mismatch($sformatf("last_char %0b, expected %0b",
                                         rsp_last_char, want.last_char));
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || (psel && penable) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("signed_integer_to_radix_digits_top_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic csr_write(input int index, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_W'(index * CSR_STRIDE);
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         int'(REG_ALPHA_LOW):  alpha_low_m = value;
         int'(REG_ALPHA_HIGH): alpha_high_m = value;
         int'(REG_BASE_LEN):   radix_m = value[RADIX_W-1:0];
         default: ;
      endcase
   endtask

   task automatic csr_check(input int index, input logic [CSR_DATA_W-1:0] want);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= CSR_ADDR_W'(index * CSR_STRIDE);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      if (prdata !== want) begin
         report_mismatch($sformatf("register %0d reads 0x%016h, expected 0x%016h",
                                   index, prdata, want));
      end
   endtask

   task automatic check_registers();
      csr_check(REG_ALPHA_LOW, alpha_low_m);
      csr_check(REG_ALPHA_HIGH, alpha_high_m);
      csr_check(REG_BASE_LEN, CSR_DATA_W'(radix_m));
   endtask

   task automatic apply_config(input logic [63:0] lo, input logic [63:0] hi,
                               input logic [RADIX_W-1:0] radix);
      csr_write(REG_ALPHA_LOW, lo);
      csr_write(REG_ALPHA_HIGH, hi);
      csr_write(REG_BASE_LEN, CSR_DATA_W'(radix));
      check_registers();
   endtask

   task automatic send_number(input logic [NUM_W-1:0] value);
      pending_numbers.push_back(value);
      numbers_sent++;
   endtask

   // Returns once every number has been taken, all text has arrived and the block is idle.
   task automatic wait_idle();
      do @(posedge clock);
      while (!(numbers_accepted == numbers_sent && chars_checked == chars_predicted && !busy));
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic make_alphabet(input int radix, output logic [127:0] alpha);
      bit   used[256];
      logic [7:0] b;
      for (int i = 0; i < 16; i++) begin
         if (i < radix) begin
            do b = 8'($urandom_range(0, 255));
            while (b == PLUS_CHAR || b == MINUS_CHAR || used[b]);
            used[b] = 1'b1;
         end else begin
            b = 8'($urandom_range(0, 255));
         end
         alpha[8*i +: 8] = b;
      end
   endtask

   function automatic logic [NUM_W-1:0] draw_number();
      logic [NUM_W-1:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = $urandom();
         4, 5:       v = NUM_W'($urandom_range(0, 40)) - NUM_W'(20);
         6: begin
            case ($urandom_range(0, 4))
               0: v = {1'b1, {(NUM_W-1){1'b0}}};
               1: v = {1'b0, {(NUM_W-1){1'b1}}};
               2: v = '0;
               3: v = '1;
               default: v = NUM_W'(1);
            endcase
         end
         default: begin
            v = NUM_W'($urandom()) >> $urandom_range(0, NUM_W - 1);
            if ($urandom_range(0, 1)) v = ~v + 1'b1;
         end
      endcase
      return v;
   endfunction

   initial begin : stimulus
      logic [127:0] alpha;
      int           radix;
      int           valid_numbers;
      int           count;
      int           i;
      int           j;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Out of reset the length is zero, so nothing may come out.
      check_registers();
      @(negedge clock);
      send_number('0);
      send_number('1);
      wait_idle();

      // Decimal; unused bytes hold signs and duplicates that must be ignored.
      apply_config(64'h3736_3534_3332_3130, 64'h2D2B_2D2B_3030_3938, 5'd10);
      @(negedge clock);
      send_number(NUM_W'(0));
      send_number(NUM_W'(7));
      send_number(-NUM_W'(7));
      send_number(NUM_W'(9));
      send_number(-NUM_W'(10));
      send_number({1'b0, {(NUM_W-1){1'b1}}});
      send_number({1'b1, {(NUM_W-1){1'b0}}});
      send_number(NUM_W'(100));
      wait_idle();

      // A write past the register list must leave the setting alone.
      csr_write(REG_UNMAPPED, '1);
      check_registers();
      @(negedge clock);
      send_number(-NUM_W'(305));
      wait_idle();

      // Binary: the most negative value gives the longest text.
      apply_config(64'h2D2B_2B30_3030_3130, 64'h2D2D_2D2D_2D2D_2D2D, 5'd2);
      @(negedge clock);
      send_number({1'b1, {(NUM_W-1){1'b0}}});
      send_number({1'b0, {(NUM_W-1){1'b1}}});
      send_number('1);
      send_number('0);
      wait_idle();

      // Sixteen digits, including a zero byte and an all-ones byte.
      apply_config(64'h3736_0034_3332_3130, 64'hFF65_6463_6261_3938, 5'd16);
      @(negedge clock);
      send_number({1'b1, {(NUM_W-1){1'b0}}});
      send_number('1);
      send_number(NUM_W'(32'h1234_5678));
      send_number(NUM_W'(15));
      send_number(-NUM_W'(15));
      wait_idle();

      // Invalid alphabets: duplicate, plus, minus, and lengths out of range.
      apply_config(64'h3736_3534_3332_3130, 64'h0000_0000_0000_3338, 5'd10);
      @(negedge clock);
      send_number(NUM_W'(42));
      wait_idle();
      apply_config(64'h3736_352B_3332_3130, 64'h0000_0000_0000_3938, 5'd10);
      @(negedge clock);
      send_number(-NUM_W'(42));
      wait_idle();
      apply_config(64'h3736_3534_3332_3130, 64'h2D65_6463_6261_3938, 5'd16);
      @(negedge clock);
      send_number(NUM_W'(1));
      wait_idle();
      apply_config(64'h3736_3534_3332_3130, 64'hFF65_6463_6261_3938, 5'd1);
      @(negedge clock);
      send_number(NUM_W'(0));
      wait_idle();
      csr_write(REG_BASE_LEN, CSR_DATA_W'(17));
      check_registers();
      @(negedge clock);
      send_number(-NUM_W'(1));
      wait_idle();
      csr_write(REG_BASE_LEN, CSR_DATA_W'(31));
      check_registers();
      @(negedge clock);
      send_number(NUM_W'(12345));
      wait_idle();

      // Random phases, mostly with valid alphabets.
      valid_numbers = 0;
      while (valid_numbers < RANDOM_NUMBERS) begin
         case ($urandom_range(0, 9))
            0:       radix = 2;
            1:       radix = RADIX_MAX;
            default: radix = $urandom_range(2, RADIX_MAX);
         endcase
         make_alphabet(RADIX_MAX, alpha);
         if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 3))
               0: begin
                  i = $urandom_range(0, radix - 2);
                  j = $urandom_range(i + 1, radix - 1);
                  alpha[8*j +: 8] = alpha[8*i +: 8];
               end
               1: alpha[8*$urandom_range(0, radix - 1) +: 8] = PLUS_CHAR;
               2: alpha[8*$urandom_range(0, radix - 1) +: 8] = MINUS_CHAR;
               default: radix = $urandom_range(0, 1) ? $urandom_range(0, 1)
                                                     : $urandom_range(RADIX_MAX + 1, 31);
            endcase
         end else begin
            make_alphabet(radix, alpha);
         end
         apply_config(alpha[63:0], alpha[127:64], RADIX_W'(radix));
         @(negedge clock);
         no_idle = ($urandom_range(0, 3) == 0);
         count = alphabet_ok() ? $urandom_range(20, 60) : $urandom_range(3, 6);
         for (int k = 0; k < count; k++) begin
            send_number(draw_number());
         end
         if (alphabet_ok()) valid_numbers += count;
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_text.size() != 0) begin
         report_mismatch($sformatf("%0d expected characters never arrived",
                                   expected_text.size()));
      end
      if (error_count == 0) begin
         $display("signed_integer_to_radix_digits_top_tb: clean");
      end else begin
         $display("signed_integer_to_radix_digits_top_tb: errors");
      end
      $finish;
   end

endmodule

@@ signed_integer_to_radix_digits_top.f @@
hdl/sitd_pkg.sv
hdl/sitd_csr.sv
hdl/sitd_dpath.sv
hdl/sitd_ctrl.sv
hdl/signed_integer_to_radix_digits_top.sv
test/signed_integer_to_radix_digits_top_tb.sv
